FILE: hw/rtl/tmbm_pkg.sv
// ----------------------------------------------------------------------------
// tmbm_pkg: shared constants and types of the battery monitor
// Window geometry, field widths, register codes and the queue item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tmbm_pkg;

  // Window geometry: the window holds SLOTS-1 samples, the trimmed mean
  // drops the largest and the smallest and divides by the rest.
  localparam int SLOTS    = 8;
  localparam int WIN      = SLOTS - 1;
  localparam int TRIM_DIV = SLOTS - 3;

  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 15;
  localparam int PCT_W    = 7;
  localparam int LIMIT_W  = 8;

  localparam int SUM_W     = $clog2(WIN * 4095 + 1);
  localparam int FILL_W    = $clog2(SLOTS + 1);
  localparam int SCAN_W    = $clog2(WIN);

  // Trimmed-sum divide by TRIM_DIV as a reciprocal multiply, exact over
  // every SUM_W-bit sum.
  localparam int RECIP_W    = SUM_W + 1;
  localparam int MEAN_SHIFT = SUM_W + $clog2(TRIM_DIV);
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'((2 ** MEAN_SHIFT + TRIM_DIV - 1) / TRIM_DIV);

  // Mean times full scale, before the divide by the full ADC code.
  localparam int PROD_W    = SAMPLE_W + MV_W;

  // Capacity divider: dividend wide enough for millivolts times 100.
  localparam int DIV_W     = MV_W + PCT_W;
  localparam int DVSR_W    = MV_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [DVSR_W-1:0] ADC_FULL_CODE = 15'd4095;
  localparam logic [PCT_W-1:0]  PCT_SCALE     = 7'd100;

  // Sample queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE  = 8'd0,
    REG_FULL_LEVEL  = 8'd1,
    REG_EMPTY_LEVEL = 8'd2,
    REG_LOW_LIMIT   = 8'd3
  } cfg_reg_t;

  localparam logic [MV_W-1:0]    RST_FULL_SCALE  = 15'd5072;
  localparam logic [MV_W-1:0]    RST_FULL_LEVEL  = 15'd4200;
  localparam logic [MV_W-1:0]    RST_EMPTY_LEVEL = 15'd3400;
  localparam logic [LIMIT_W-1:0] RST_LOW_LIMIT   = 8'd2;

  typedef struct packed {
    logic [MV_W-1:0]    full_scale_mv;
    logic [MV_W-1:0]    full_level_mv;
    logic [MV_W-1:0]    empty_level_mv;
    logic [LIMIT_W-1:0] low_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                has_result;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tmbm_front.sv
// ----------------------------------------------------------------------------
// tmbm_front: sample intake
// Accepts samples, tracks window fill and tags each item with whether it
// produces a result.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [tmbm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          q_full,
  output      logic                          q_push,
  output      tmbm_pkg::q_item_t             q_item
);

  logic [tmbm_pkg::FILL_W-1:0] fill_count;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign q_item.sample     = in_sample;
  assign q_item.has_result =
    (fill_count >= tmbm_pkg::FILL_W'(tmbm_pkg::SLOTS - 1));

  // Count up to SLOTS, then hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (q_push && (fill_count < tmbm_pkg::FILL_W'(tmbm_pkg::SLOTS))) begin
      fill_count <= fill_count + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmbm_queue.sv
// ----------------------------------------------------------------------------
// tmbm_queue: item queue
// Small FIFO that decouples the intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbm_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tmbm_pkg::q_item_t push_item,
  output      logic              full,
  input  wire logic              pop,
  output      logic              valid,
  output      tmbm_pkg::q_item_t pop_item
);

  tmbm_pkg::q_item_t            entries [tmbm_pkg::QDEPTH];
  logic [tmbm_pkg::QAW-1:0]     wr_ptr;
  logic [tmbm_pkg::QAW-1:0]     rd_ptr;
  logic [tmbm_pkg::QAW:0]       count;

  assign full     = (count == (tmbm_pkg::QAW + 1)'(tmbm_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tmbm_pkg::QAW'(tmbm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tmbm_pkg::QAW'(tmbm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmbm_div.sv
// ----------------------------------------------------------------------------
// tmbm_div: unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tmbm_pkg::div_req_t         req,
  output      logic                       done,
  output      logic [tmbm_pkg::DIV_W-1:0] quotient
);

  logic                           busy;
  logic [tmbm_pkg::DIV_CNT_W-1:0] step;
  logic [tmbm_pkg::DVSR_W-1:0]    rem;
  logic [tmbm_pkg::DVSR_W-1:0]    dvsr;
  logic [tmbm_pkg::DVSR_W:0]      trial;
  logic                           fits;

  assign trial = {rem, quotient[tmbm_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (step == tmbm_pkg::DIV_CNT_W'(tmbm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end else if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

  // Shift the dividend out of the quotient register as quotient bits come in.
  always_ff @(posedge clk) begin
    if (busy) begin
      rem      <= fits ? tmbm_pkg::DVSR_W'(trial - {1'b0, dvsr})
                       : trial[tmbm_pkg::DVSR_W-1:0];
      quotient <= {quotient[tmbm_pkg::DIV_W-2:0], fits};
    end else if (req.start) begin
      rem      <= '0;
      dvsr     <= req.divisor;
      quotient <= req.dividend;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmbm_back.sv
// ----------------------------------------------------------------------------
// tmbm_back: arithmetic sequencer
// Shifts the window, scans it for sum, max and min, forms the mean and the
// millivolt reading, runs the capacity division and the low-run logic, and
// holds the result for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbm_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tmbm_pkg::cfg_t               cfg,
  input  wire logic                         q_valid,
  input  wire tmbm_pkg::q_item_t            q_item,
  output      logic                         q_pop,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [tmbm_pkg::MV_W-1:0]    out_mv,
  output      logic [tmbm_pkg::PCT_W-1:0]   out_pct,
  output      logic                         out_shut
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MEAN,
    S_SCALE,
    S_FOLD,
    S_MV,
    S_CLASS,
    S_PCT_GO,
    S_DIV_PCT,
    S_EMIT
  } state_t;

  state_t                          state;
  logic [tmbm_pkg::SAMPLE_W-1:0]   win [tmbm_pkg::WIN];
  logic [tmbm_pkg::SCAN_W-1:0]     scan_idx;
  logic [tmbm_pkg::SUM_W-1:0]      sum;
  logic [tmbm_pkg::SAMPLE_W-1:0]   mx;
  logic [tmbm_pkg::SAMPLE_W-1:0]   mn;
  logic [tmbm_pkg::SAMPLE_W-1:0]   mean;
  logic [tmbm_pkg::SUM_W+tmbm_pkg::RECIP_W-1:0] mean_prod;
  logic [tmbm_pkg::PROD_W-1:0]     prod;
  logic [tmbm_pkg::MV_W-1:0]       fold_q;
  logic [tmbm_pkg::MV_W:0]         fold_r;
  logic [tmbm_pkg::MV_W-tmbm_pkg::SAMPLE_W:0] fold_q1;
  logic [tmbm_pkg::SAMPLE_W:0]     fold_r2;
  logic                            fold_fix;
  logic [tmbm_pkg::DIV_W-1:0]      num;
  logic [tmbm_pkg::MV_W-1:0]       mv;
  logic [tmbm_pkg::PCT_W-1:0]      pct;
  logic                            shut;
  logic [tmbm_pkg::LIMIT_W-1:0]    low_run;
  logic [tmbm_pkg::LIMIT_W:0]      run_inc;
  logic [tmbm_pkg::SUM_W-1:0]      trim;
  logic [tmbm_pkg::MV_W-1:0]       mv_raw;
  tmbm_pkg::div_req_t              div_req;
  logic                            div_done;
  logic [tmbm_pkg::DIV_W-1:0]      div_q;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign run_inc = {1'b0, low_run} + 1'b1;
  assign trim    = sum - tmbm_pkg::SUM_W'(mx) - tmbm_pkg::SUM_W'(mn);

  // Trimmed sum over TRIM_DIV by reciprocal multiply.
  assign mean_prod = (tmbm_pkg::SUM_W + tmbm_pkg::RECIP_W)'(trim) *
                     (tmbm_pkg::SUM_W + tmbm_pkg::RECIP_W)'(tmbm_pkg::MEAN_RECIP);

  // Divide by 4095 = 4096 - 1: fold the high part back onto the low part
  // twice, then one compare settles the last quotient bit.
  assign fold_q1  = fold_r[tmbm_pkg::MV_W:tmbm_pkg::SAMPLE_W];
  assign fold_r2  = {1'b0, fold_r[tmbm_pkg::SAMPLE_W-1:0]} +
                    (tmbm_pkg::SAMPLE_W + 1)'(fold_q1);
  assign fold_fix = (fold_r2 >= (tmbm_pkg::SAMPLE_W + 1)'(tmbm_pkg::ADC_FULL_CODE));
  assign mv_raw   = fold_q + tmbm_pkg::MV_W'(fold_q1) + tmbm_pkg::MV_W'(fold_fix);

  assign div_req.start    = (state == S_PCT_GO);
  assign div_req.dividend = num;
  assign div_req.divisor  = cfg.full_level_mv - cfg.empty_level_mv;

  tmbm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      low_run   <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            // Drop the oldest sample, append the new one.
            for (int i = 0; i < tmbm_pkg::WIN - 1; i++) begin
              win[i] <= win[i+1];
            end
            win[tmbm_pkg::WIN-1] <= q_item.sample;
            if (q_item.has_result) begin
              scan_idx <= '0;
              sum      <= '0;
              mx       <= '0;
              mn       <= '1;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Rotate the window once around, reading the head each cycle.
          for (int i = 0; i < tmbm_pkg::WIN - 1; i++) begin
            win[i] <= win[i+1];
          end
          win[tmbm_pkg::WIN-1] <= win[0];
          sum <= sum + tmbm_pkg::SUM_W'(win[0]);
          if (win[0] > mx) begin
            mx <= win[0];
          end
          if (win[0] < mn) begin
            mn <= win[0];
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == tmbm_pkg::SCAN_W'(tmbm_pkg::WIN - 1)) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean  <= mean_prod[tmbm_pkg::MEAN_SHIFT +: tmbm_pkg::SAMPLE_W];
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= tmbm_pkg::PROD_W'(mean) * tmbm_pkg::PROD_W'(cfg.full_scale_mv);
          state <= S_FOLD;
        end
        S_FOLD: begin
          fold_q <= prod[tmbm_pkg::PROD_W-1:tmbm_pkg::SAMPLE_W];
          fold_r <= (tmbm_pkg::MV_W + 1)'(prod[tmbm_pkg::SAMPLE_W-1:0]) +
                    (tmbm_pkg::MV_W + 1)'(prod[tmbm_pkg::PROD_W-1:tmbm_pkg::SAMPLE_W]);
          state  <= S_MV;
        end
        S_MV: begin
          mv    <= (mv_raw > cfg.full_level_mv) ? cfg.full_level_mv : mv_raw;
          state <= S_CLASS;
        end
        S_CLASS: begin
          if (mv > cfg.empty_level_mv) begin
            num     <= tmbm_pkg::DIV_W'(mv - cfg.empty_level_mv) *
                       tmbm_pkg::DIV_W'(tmbm_pkg::PCT_SCALE);
            low_run <= '0;
            shut    <= 1'b0;
            state   <= S_PCT_GO;
          end else begin
            pct <= '0;
            if (run_inc > {1'b0, cfg.low_count_limit}) begin
              shut    <= 1'b1;
              low_run <= '0;
            end else begin
              shut    <= 1'b0;
              low_run <= run_inc[tmbm_pkg::LIMIT_W-1:0];
            end
            state <= S_EMIT;
          end
        end
        S_PCT_GO: begin
          state <= S_DIV_PCT;
        end
        S_DIV_PCT: begin
          if (div_done) begin
            pct   <= div_q[tmbm_pkg::PCT_W-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_mv    <= mv;
            out_pct   <= pct;
            out_shut  <= shut;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trimmed_mean_battery_monitor.sv
// ----------------------------------------------------------------------------
// trimmed_mean_battery_monitor: sliding-window battery voltage monitor
// Trimmed mean of the recent ADC samples, scaled to millivolts, with a
// capacity percentage and a low-voltage shutdown request.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata[11:0] adc_sample
//  m_*      out  m_tvalid/m_tready    tdata[14:0] voltage_mv, [21:15] capacity_pct;
//                                     tuser[0] shutdown
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
//  Sequencing: a sample that gives no result only shifts the window; one that
//  gives a result also passes through the window scan, the mean and scaling
//  steps and, when the reading is above the empty level, the bit-serial
//  capacity divider.
//  Reset: synchronous, clears window fill, low-run count, queue and handshakes.
//  Stalls: a two-item queue parts intake from the sequencer, and the output
//  register lets the sequencer start the next item while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_battery_monitor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // s_tdata: [11:0] adc_sample, [15:12] zero
  input  wire logic [tmbm_pkg::IN_TDATA_W-1:0]   s_tdata,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: [14:0] voltage_mv, [21:15] capacity_pct, [23:22] zero
  output      logic [tmbm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // m_tuser: [0] shutdown
  output      logic                              m_tuser,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [tmbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tmbm_pkg::cfg_t                cfg;
  logic                          q_full;
  logic                          q_push;
  tmbm_pkg::q_item_t             push_item;
  logic                          q_valid;
  logic                          q_pop;
  tmbm_pkg::q_item_t             pop_item;
  logic [tmbm_pkg::MV_W-1:0]     out_mv;
  logic [tmbm_pkg::PCT_W-1:0]    out_pct;

  // Registers are always writable; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_scale_mv   <= tmbm_pkg::RST_FULL_SCALE;
      cfg.full_level_mv   <= tmbm_pkg::RST_FULL_LEVEL;
      cfg.empty_level_mv  <= tmbm_pkg::RST_EMPTY_LEVEL;
      cfg.low_count_limit <= tmbm_pkg::RST_LOW_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmbm_pkg::REG_FULL_SCALE:  cfg.full_scale_mv   <= cfg_data[tmbm_pkg::MV_W-1:0];
        tmbm_pkg::REG_FULL_LEVEL:  cfg.full_level_mv   <= cfg_data[tmbm_pkg::MV_W-1:0];
        tmbm_pkg::REG_EMPTY_LEVEL: cfg.empty_level_mv  <= cfg_data[tmbm_pkg::MV_W-1:0];
        tmbm_pkg::REG_LOW_LIMIT:   cfg.low_count_limit <= cfg_data[tmbm_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Intake: accept samples and tag those that complete a window.
  tmbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[tmbm_pkg::SAMPLE_W-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Hold items until the sequencer is free.
  tmbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  // Window, trimmed mean, scaling, capacity and shutdown.
  tmbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mv    (out_mv),
    .out_pct   (out_pct),
    .out_shut  (m_tuser)
  );

  assign m_tdata = {{(tmbm_pkg::OUT_TDATA_W - tmbm_pkg::MV_W - tmbm_pkg::PCT_W){1'b0}},
                    out_pct, out_mv};

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trimmed-mean battery monitor
// Streams ADC samples into the block and checks every reading (millivolts,
// capacity percent, shutdown pulse) against a cycle-free model of the
// window, the trimmed mean and the low-voltage run counter. A short table
// of directed samples comes first, then randomized phases under several
// register settings, with random idles on both stream sides.
// ----------------------------------------------------------------------------

module tb_top;
  import tmbm_pkg::*;

  // Run limits: the slowest correct run adds the longest sender gap and receiver
  // stall to every item's time in the block.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 150;
  localparam int          MAX_REPORTS   = 40;

  // Index outside the register map: the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             shutdown;
  } reading_t;

  // One row of the directed table: the sample, and a hand-typed reading
  // where one is given (typed = 1); other rows use the predictor.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    logic [MV_W-1:0]     mv;
    logic [PCT_W-1:0]    pct;
    logic                shutdown;
  } stim_row_t;

  typedef enum int {
    MIX_SPREAD,      // uniform codes with extremes mixed in
    MIX_NEAR_EMPTY,  // codes around the empty threshold, with spikes
    MIX_MOSTLY_LOW   // long runs below the threshold
  } sample_mix_t;

  // Defaults after reset: 5072 mV full scale, 4200 full, 3400 empty, limit 2.
  // A window of 4095 clamps to the full level at 100 percent; one zero in the
  // window is trimmed off as the minimum, so the reading stays the same.
  localparam int DIRECTED_ROWS = 24;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},  // fill: no reading yet
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd4095, 1'b1, 15'd4200, 7'd100, 1'b0},  // first reading, clamped
    '{12'd0,    1'b1, 15'd4200, 7'd100, 1'b0},  // lone zero trimmed off
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},  // mean falls, still above empty
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},  // low run reaches limit
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd0,    1'b0, 15'd0,    7'd0,   1'b0},  // window all zero
    '{12'd4095, 1'b0, 15'd0,    7'd0,   1'b0},  // lone spike trimmed off
    '{12'd2746, 1'b0, 15'd0,    7'd0,   1'b0},  // just above empty level
    '{12'd2746, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd2746, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd2746, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd2745, 1'b0, 15'd0,    7'd0,   1'b0},  // just below empty level
    '{12'd2745, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd2048, 1'b0, 15'd0,    7'd0,   1'b0},
    '{12'd1,    1'b0, 15'd0,    7'd0,   1'b0}
  };

  // DUT ports; the inputs are all driven to known values from time zero.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Predictor state: its own copy of the window, fill count, run count and
  // register settings.
  logic [SAMPLE_W-1:0] recent_samples [WIN];
  int unsigned         samples_seen;
  logic [LIMIT_W-1:0]  low_streak;
  cfg_t                settings;

  reading_t    pending_readings [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;

  trimmed_mean_battery_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost reading ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d (cycle %0d)", what, want, got,
               cycle_count);
  endtask

  // Shift a sample into the window and form the reading it causes, if any.
  // Returns 0 while the window is still filling after reset.
  function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] sample,
                                       output reading_t r);
    int unsigned     total, hi, lo, mean, mv, pct, run;
    longint unsigned scaled;
    r = '0;
    for (int i = 0; i < WIN - 1; i++)
      recent_samples[i] = recent_samples[i + 1];
    recent_samples[WIN - 1] = sample;
    if (samples_seen < SLOTS)
      samples_seen++;
    if (samples_seen < SLOTS)
      return 1'b0;

    hi = recent_samples[0];
    lo = recent_samples[0];
    total = 0;
    for (int i = 0; i < WIN; i++) begin
      if (recent_samples[i] > hi) hi = recent_samples[i];
      if (recent_samples[i] < lo) lo = recent_samples[i];
      total += recent_samples[i];
    end
    mean = ((total - hi - lo) / TRIM_DIV) & 32'hFFF;

    scaled = mean;
    scaled = scaled * settings.full_scale_mv / ADC_FULL_CODE;
    mv = (scaled > settings.full_level_mv) ? settings.full_level_mv : scaled[31:0];

    // Above empty implies full > empty, so the divisor is never zero here.
    if (mv > settings.empty_level_mv)
      pct = (mv - settings.empty_level_mv) * 100 /
            (settings.full_level_mv - settings.empty_level_mv);
    else
      pct = 0;

    r.shutdown = 1'b0;
    if (mv <= settings.empty_level_mv) begin
      run = int'(low_streak) + 1;
      if (run > settings.low_count_limit) begin
        r.shutdown = 1'b1;
        low_streak = '0;
      end else begin
        low_streak = run[LIMIT_W-1:0];
      end
    end else begin
      low_streak = '0;
    end
    r.mv  = mv[MV_W-1:0];
    r.pct = pct[PCT_W-1:0];
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ADC code whose reading sits at the empty level under current settings.
  function automatic int empty_code();
    int code;
    code = (settings.full_scale_mv == 0) ? 4095 :
           settings.empty_level_mv * 4095 / settings.full_scale_mv;
    return (code > 4095) ? 4095 : code;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
    int roll, code;
    roll = $urandom_range(0, 9);
    case (mix)
      MIX_NEAR_EMPTY: begin
        if (roll == 0)
          code = $urandom_range(0, 1) ? 4095 : 0;
        else
          code = empty_code() + $urandom_range(0, 64) - 32;
      end
      MIX_MOSTLY_LOW: begin
        code = (roll < 8) ? $urandom_range(0, empty_code()) : $urandom_range(0, 4095);
      end
      default: begin
        if (roll == 0)
          code = $urandom_range(0, 1) ? 4095 : 0;
        else
          code = $urandom_range(0, 4095);
      end
    endcase
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    return code[SAMPLE_W-1:0];
  endfunction

  // Offer one sample; predict at the accepting edge. With gap 0 tvalid stays
  // high so the next call can present its item on the following cycle.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input int gap,
                             input bit typed, input reading_t typed_reading);
    reading_t predicted;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (absorb_sample(sample, predicted))
      pending_readings.push_back(typed ? typed_reading : predicted);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop tvalid and hold until every reading is back.
  task automatic drain_readings();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Before a register write: drain, then let any sample that gives no
  // reading clear the sequencer.
  task automatic settle_idle();
    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FULL_SCALE:  settings.full_scale_mv   = value[MV_W-1:0];
      REG_FULL_LEVEL:  settings.full_level_mv   = value[MV_W-1:0];
      REG_EMPTY_LEVEL: settings.empty_level_mv  = value[MV_W-1:0];
      REG_LOW_LIMIT:   settings.low_count_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: program all registers, then stream samples. Every
  // fourth stretch of 32 items runs back to back; midway, hold off until
  // the block has delivered everything.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] full_scale,
                           input logic [CFG_DATA_W-1:0] full_level,
                           input logic [CFG_DATA_W-1:0] empty_level,
                           input logic [CFG_DATA_W-1:0] low_limit,
                           input int count, input sample_mix_t mix);
    int gap;
    settle_idle();
    write_reg(REG_FULL_SCALE, full_scale);
    write_reg(REG_FULL_LEVEL, full_level);
    write_reg(REG_EMPTY_LEVEL, empty_level);
    write_reg(REG_LOW_LIMIT, low_limit);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        drain_readings();
      gap = ((i / 32) % 4 == 3) ? 0 : pick_gap();
      send_sample(draw_sample(mix), gap, 1'b0, '0);
    end
  endtask

  // Receiver: ready runs of random length, stalls from the same gap mix,
  // and now and then a long stretch of steady ready.
  initial begin : drive_ready
    int hold_hi, stall;
    forever begin
      hold_hi = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
      repeat (hold_hi) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
    end
  end

  // Compare each accepted reading with the oldest prediction.
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending", 0, m_tdata);
      end else begin
        want = pending_readings.pop_front();
        if (m_tdata[MV_W-1:0] !== want.mv)
          report_mismatch("voltage_mv", want.mv, m_tdata[MV_W-1:0]);
        if (m_tdata[MV_W+PCT_W-1:MV_W] !== want.pct)
          report_mismatch("capacity_pct", want.pct, m_tdata[MV_W+PCT_W-1:MV_W]);
        if (m_tuser !== want.shutdown)
          report_mismatch("shutdown", want.shutdown, m_tuser);
        if (m_tdata[OUT_TDATA_W-1:MV_W+PCT_W] !== '0)
          report_mismatch("tdata pad", 0, m_tdata[OUT_TDATA_W-1:MV_W+PCT_W]);
      end
    end
  end

  initial begin : stimulus
    reading_t  typed_reading;
    stim_row_t row;
    logic [CFG_DATA_W-1:0] level;

    // Predictor starts from the reset state.
    settings.full_scale_mv   = RST_FULL_SCALE;
    settings.full_level_mv   = RST_FULL_LEVEL;
    settings.empty_level_mv  = RST_EMPTY_LEVEL;
    settings.low_count_limit = RST_LOW_LIMIT;
    for (int i = 0; i < WIN; i++) recent_samples[i] = '0;
    samples_seen = 0;
    low_streak   = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset settings: fill, clamp, trim of a lone
    // extreme, equal window, low run into shutdown, both sides of empty.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      typed_reading = '{mv: row.mv, pct: row.pct, shutdown: row.shutdown};
      send_sample(row.sample, pick_gap(), row.typed, typed_reading);
    end

    // Random settings in range, with the empty level at or under the full level.
    level = $urandom_range(2000, 20000);
    run_phase($urandom_range(1000, 20000), level, $urandom_range(0, level),
              $urandom_range(0, 6), 150, MIX_SPREAD);

    // Smallest scale and zero levels: every reading is low and, with a zero
    // limit, every reading requests shutdown.
    run_phase(16'd1000, 16'd0, 16'd0, 16'd0, 60, MIX_SPREAD);

    // Full level equal to empty level: capacity stays zero, every reading is
    // low. Limit written with high bits set; the 256th low reading shuts down.
    run_phase(16'd20000, 16'd20000, 16'd20000, 16'hFFFF, 270, MIX_SPREAD);

    // Largest scale, written with bit 15 set; capacity over the full range.
    run_phase(16'h8000 | 16'd20000, 16'd20000, 16'd0, 16'd5, 100, MIX_MOSTLY_LOW);

    // Back to the reset values; an unmapped index must change nothing.
    settle_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    run_phase(RST_FULL_SCALE, RST_FULL_LEVEL, RST_EMPTY_LEVEL, RST_LOW_LIMIT, 150,
              MIX_NEAR_EMPTY);

    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
